FILE: src/cht_pkg.sv
package cht_pkg;

	localparam int BUCKETS = 10;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int BKT_W = 4;
	localparam int SLOT_W = 3;
	localparam int COUNT_W = 7;
	localparam int BLEN_W = 4;

	// ceil(2^35 / 10): exact quotient by ten for any 32-bit dividend
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		op_t               operation;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [BKT_W-1:0]  bucket;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] entry_count;
		logic [BLEN_W-1:0]  bucket_length;
		logic [KEY_W-1:0]   entry_key;
		logic [VAL_W-1:0]   entry_value;
	} rsp_t;

endpackage

FILE: src/chained_hash_table_core.sv
// Chained hash table: ten buckets selected by key mod 10, each an ordered list
// of up to SLOTS key/value entries held in one simple dual-port RAM.
//
// Request channel (req_valid/req_stall/req): one beat per operation - add,
// delete, find, or read of the entry at bucket/slot. Response channel
// (rsp_valid/rsp_stall/rsp): exactly one beat per request, in order.
//
// Steps from request beat to response beat, with L the bucket length:
//   read          hash, setup, one RAM read if the slot is in use, push
//   find, add     hash, setup, scan of up to L slots, act, push
//   delete        as find; on a match the scan stops there, then the tail
//                 is moved up one slot before the push
// Each scanned or moved slot takes one read of the RAM read port, and one
// operation is worked on at a time; a new request is taken once the previous
// response is in the output register.
//
// Reset clears all bucket lengths and the entry count; the RAM is not cleared,
// slots beyond a bucket's length are never used. If the receiver stalls, the
// response is held in the output register; the next request is still taken
// and processed, and its response waits until the output register is free.
module chained_hash_table_core #(
	parameter int SLOTS = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  cht_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cht_pkg::rsp_t   rsp
);

	localparam int DEPTH = cht_pkg::BUCKETS * SLOTS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int TOT_W = $clog2(DEPTH + 1);
	localparam int ENTRY_W = cht_pkg::KEY_W + VALUE_BITS;
	localparam int QUO_W = cht_pkg::KEY_W + 32 - cht_pkg::RECIP_SHIFT;

	typedef enum logic [3:0] {
		S_IDLE, S_HASH1, S_HASH2, S_SETUP, S_SCAN, S_RDWAIT, S_ACT, S_SHIFT, S_PUSH
	} state_t;

	state_t                        state_q;
	cht_pkg::req_t                 req_q;
	logic [QUO_W-1:0]              quo_q;
	logic [cht_pkg::BKT_W-1:0]     bkt_q;
	logic [ADDR_W-1:0]             base_q;
	logic [CNT_W-1:0]              blen_q;
	logic [CNT_W-1:0]              idx_q;
	logic [CNT_W-1:0]              pos_q;
	logic                          found_q;
	logic                          rv_s1;
	logic [CNT_W-1:0]              rd_idx_s1;
	logic                          wp_s1;
	logic [CNT_W-1:0]              wr_idx_s1;
	cht_pkg::status_t              status_q;
	logic [cht_pkg::KEY_W-1:0]     okey_q;
	logic [cht_pkg::VAL_W-1:0]     oval_q;
	logic [CNT_W-1:0]              lens_q [cht_pkg::BUCKETS];
	logic [TOT_W-1:0]              total_q;
	logic                          rsp_valid_q;
	cht_pkg::rsp_t                 rsp_q;

	logic [ENTRY_W-1:0]            mem [DEPTH];
	logic [ENTRY_W-1:0]            mem_rdata_q;
	logic [ADDR_W-1:0]             mem_raddr;
	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_waddr;
	logic [ENTRY_W-1:0]            mem_wdata;

	logic [62:0]                   prod;
	logic [31:0]                   q_ten;
	logic [31:0]                   rem;
	logic                          bkt_ok;
	logic [CNT_W-1:0]              len_c;
	logic                          rd_hit;
	logic [cht_pkg::KEY_W-1:0]     rd_key;
	logic [VALUE_BITS-1:0]         rd_val;
	logic                          scan_issue;
	logic                          scan_match;
	logic                          shift_issue;
	logic                          add_ok;

	assign prod = 63'(req_q.key) * 63'(cht_pkg::RECIP_TEN);
	assign q_ten = (32'(quo_q) << 3) + (32'(quo_q) << 1);
	assign rem = 32'(req_q.key) - q_ten;

	assign bkt_ok = 32'(bkt_q) < cht_pkg::BUCKETS;
	assign len_c = bkt_ok ? lens_q[bkt_q] : '0;
	assign rd_hit = bkt_ok && (32'(req_q.slot) < 32'(len_c)) && (32'(req_q.slot) < SLOTS);

	assign rd_key = mem_rdata_q[ENTRY_W-1 -: cht_pkg::KEY_W];
	assign rd_val = mem_rdata_q[VALUE_BITS-1:0];

	assign scan_issue = idx_q < blen_q;
	assign scan_match = rv_s1 && (rd_key == req_q.key);
	assign shift_issue = idx_q < blen_q;
	assign add_ok = !found_q && (32'(blen_q) < SLOTS);

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		mem_raddr = base_q + ADDR_W'(idx_q);
		mem_we = 1'b0;
		mem_waddr = base_q + ADDR_W'(blen_q);
		mem_wdata = {req_q.key, VALUE_BITS'(req_q.value)};
		unique case (state_q)
			S_SETUP: begin
				mem_raddr = ADDR_W'(bkt_q * SLOTS) + ADDR_W'(req_q.slot);
			end
			S_ACT: begin
				mem_we = (req_q.operation == cht_pkg::OP_ADD) && add_ok;
			end
			S_SHIFT: begin
				// move the slot read last cycle up by one
				mem_we = wp_s1;
				mem_waddr = base_q + ADDR_W'(wr_idx_s1);
				mem_wdata = mem_rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			quo_q <= '0;
			bkt_q <= '0;
			base_q <= '0;
			blen_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			rv_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			wp_s1 <= 1'b0;
			wr_idx_s1 <= '0;
			status_q <= cht_pkg::ST_ABSENT;
			okey_q <= '0;
			oval_q <= '0;
			for (int b = 0; b < cht_pkg::BUCKETS; b++) begin
				lens_q[b] <= '0;
			end
			total_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			// S_PUSH loads the next beat itself when the current one leaves
			if (rsp_valid_q && !rsp_stall && state_q != S_PUSH) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						state_q <= S_HASH1;
					end
				end
				S_HASH1: begin
					quo_q <= prod[62 -: QUO_W];
					state_q <= S_HASH2;
				end
				S_HASH2: begin
					bkt_q <= (req_q.operation == cht_pkg::OP_READ) ? req_q.bucket
						: cht_pkg::BKT_W'(rem);
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					base_q <= ADDR_W'(bkt_q * SLOTS);
					blen_q <= len_c;
					idx_q <= '0;
					found_q <= 1'b0;
					rv_s1 <= 1'b0;
					okey_q <= '0;
					oval_q <= '0;
					status_q <= cht_pkg::ST_ABSENT;
					if (req_q.operation == cht_pkg::OP_READ) begin
						state_q <= rd_hit ? S_RDWAIT : S_PUSH;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_RDWAIT: begin
					okey_q <= rd_key;
					oval_q <= 32'(rd_val);
					status_q <= cht_pkg::ST_OK;
					state_q <= S_PUSH;
				end
				S_SCAN: begin
					// one read issued per cycle, compared the cycle after
					rv_s1 <= scan_issue;
					rd_idx_s1 <= idx_q;
					if (scan_match) begin
						found_q <= 1'b1;
						pos_q <= rd_idx_s1;
						oval_q <= (req_q.operation == cht_pkg::OP_FIND) ? 32'(rd_val) : '0;
						state_q <= S_ACT;
					end else if (!scan_issue && !rv_s1) begin
						state_q <= S_ACT;
					end else if (scan_issue) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_ACT: begin
					unique case (req_q.operation)
						cht_pkg::OP_ADD: begin
							if (found_q) begin
								status_q <= cht_pkg::ST_ABSENT;
							end else if (!add_ok) begin
								status_q <= cht_pkg::ST_FULL;
							end else begin
								status_q <= cht_pkg::ST_OK;
								lens_q[bkt_q] <= blen_q + 1'b1;
								blen_q <= blen_q + 1'b1;
								total_q <= total_q + 1'b1;
							end
							state_q <= S_PUSH;
						end
						cht_pkg::OP_DELETE: begin
							if (found_q) begin
								idx_q <= pos_q + 1'b1;
								wp_s1 <= 1'b0;
								state_q <= S_SHIFT;
							end else begin
								status_q <= cht_pkg::ST_ABSENT;
								state_q <= S_PUSH;
							end
						end
						default: begin
							status_q <= found_q ? cht_pkg::ST_OK : cht_pkg::ST_ABSENT;
							state_q <= S_PUSH;
						end
					endcase
				end
				S_SHIFT: begin
					wp_s1 <= shift_issue;
					wr_idx_s1 <= idx_q - 1'b1;
					if (shift_issue) begin
						idx_q <= idx_q + 1'b1;
					end else if (!wp_s1) begin
						lens_q[bkt_q] <= blen_q - 1'b1;
						blen_q <= blen_q - 1'b1;
						total_q <= total_q - 1'b1;
						status_q <= cht_pkg::ST_OK;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status <= status_q;
						rsp_q.entry_count <= cht_pkg::COUNT_W'(total_q);
						rsp_q.bucket_length <= cht_pkg::BLEN_W'(blen_q);
						rsp_q.entry_key <= okey_q;
						rsp_q.entry_value <= oval_q;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= DEPTH)
		else $error("entry count beyond capacity");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_ACT || state_q == S_SHIFT))
		else $error("RAM written outside add or compaction");

	a_total_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_ACT && state_q != S_SHIFT) |=> $stable(total_q))
		else $error("entry count changed outside an update");

	a_full_is_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && status_q == cht_pkg::ST_FULL)
		|-> (req_q.operation == cht_pkg::OP_ADD && 32'(blen_q) == SLOTS))
		else $error("full status without a full bucket on add");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && rv_s1) |-> rd_idx_s1 < blen_q)
		else $error("scan compared a slot beyond the bucket length");

endmodule
